[sv/bia_pkg.sv]
// Shared opcodes, status codes, control structs and state type for the ID allocator.
`default_nettype none
package bia_pkg;

	localparam logic [2:0] OP_ALLOC_HOST  = 3'd0;
	localparam logic [2:0] OP_ALLOC_LOCAL = 3'd1;
	localparam logic [2:0] OP_FREE        = 3'd2;
	localparam logic [2:0] OP_REG_MIRROR  = 3'd3;
	localparam logic [2:0] OP_UNREG       = 3'd4;
	localparam logic [2:0] OP_LOOKUP      = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NULL_HDL  = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED = 3'd2;
	localparam logic [2:0] ST_BAD_ID    = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;
	localparam logic [2:0] ST_OCCUPIED  = 3'd5;

	typedef enum logic [0:0] {
		FSM_IDLE,
		FSM_EXEC
	} fsm_state_t;

	typedef struct packed {
		logic load;
		logic pop;
		logic push;
	} stk_ctrl_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} map_ctrl_t;

endpackage
`default_nettype wire

[sv/bia_id_map.sv]
// ID-to-handle map: one synchronous RAM with a clearing sweep after reset.
`default_nettype none
module bia_id_map #(
	parameter int DEPTH = 4096,
	parameter int DW    = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  bia_pkg::map_ctrl_t      ctrl,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [DW-1:0]            wr_data,
	output logic [DW-1:0]           rd_data,
	output logic                    clearing
);
	import bia_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [DW-1:0] mem [DEPTH];
	logic [AW-1:0] clr_cnt_q;
	logic          clearing_q;
	logic [DW-1:0] rd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// sweep zeros through every entry before the first access
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_s1;
	assign clearing = clearing_q;

	a_no_wr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !ctrl.wr_en)
		else $error("map write during clearing sweep");
	a_no_rd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !ctrl.rd_en)
		else $error("map read during clearing sweep");
	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> $past(clr_cnt_q) == AW'(DEPTH - 1))
		else $error("clearing sweep ended early");

endmodule
`default_nettype wire

[sv/bia_free_stack.sv]
// LIFO free-ID stack in a synchronous RAM; entries below the low-water mark come from the fill pattern.
`default_nettype none
module bia_free_stack #(
	parameter int DEPTH     = 2047,
	parameter int IDW       = 12,
	parameter int RST_TOP   = 2047,
	parameter int RST_LEVEL = 2047
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  bia_pkg::stk_ctrl_t        ctrl,
	input  wire [$clog2(DEPTH+1)-1:0] load_level,
	input  wire [IDW-1:0]             load_top,
	input  wire [IDW-1:0]             push_id,
	output logic [$clog2(DEPTH+1)-1:0] level,
	output logic [IDW-1:0]            pop_id
);
	import bia_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	logic [IDW-1:0] mem [DEPTH];
	logic [LW-1:0]  level_q;
	logic [LW-1:0]  low_q;
	logic [IDW-1:0] top_q;
	logic [IDW-1:0] rd_data_s1;
	logic [IDW-1:0] init_id_s1;
	logic           use_init_s1;
	logic [LW-1:0]  level_m1;
	logic           not_full;

	assign level_m1 = level_q - LW'(1);
	assign not_full = (level_q < LW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LW'(RST_LEVEL);
			low_q       <= LW'(RST_LEVEL);
			top_q       <= IDW'(RST_TOP);
			use_init_s1 <= 1'b0;
		end else if (ctrl.load) begin
			level_q <= load_level;
			low_q   <= load_level;
			top_q   <= load_top;
		end else if (ctrl.pop) begin
			use_init_s1 <= (level_q == low_q);
			level_q     <= level_m1;
			// entry never overwritten since the fill: lower the mark with it
			if (level_q == low_q) begin
				low_q <= level_m1;
			end
		end else if (ctrl.push && not_full) begin
			level_q <= level_q + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push && not_full) begin
			mem[level_q[AW-1:0]] <= push_id;
		end
		if (ctrl.pop) begin
			rd_data_s1 <= mem[level_m1[AW-1:0]];
			init_id_s1 <= top_q - IDW'(level_m1);
		end
	end

	assign level  = level_q;
	assign pop_id = use_init_s1 ? init_id_s1 : rd_data_s1;

	a_low_mark: assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= level_q)
		else $error("low-water mark above level");
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(DEPTH))
		else $error("stack level beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> level_q != '0)
		else $error("pop from empty stack");
	a_pop_push: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.pop && ctrl.push))
		else $error("pop and push in the same cycle");

endmodule
`default_nettype wire

[sv/banded_id_allocator_with_lookup.sv]
// Top level: command sequencer, band registers and result registers around map and stacks.
// An item is taken when start is high and busy is low; it passes through the
// accept stage (map read and stack pop issued to the RAMs) and then the
// execute stage (map write, stack push), and busy stays high during execute,
// so a new item is taken only after the last one has left execute. The result
// appears on the result ports with done high for exactly one cycle, the cycle
// after execute; the receiver cannot stall it, so it must sample on that edge.
// After reset busy stays high while the map RAM is swept to zero. The peer_band
// register may be written at any time the block is idle.
`default_nettype none
module banded_id_allocator_with_lookup #(
	parameter int TOTAL_IDS  = 4096,
	parameter int HOST_IDS   = 2048,
	parameter int PEER_BANDS = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  opcode,
	input  wire  [15:0] element_id,
	input  wire  [15:0] handle,
	input  wire         peer_band_we,
	input  wire  [1:0]  peer_band,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] result_id,
	output logic [15:0] found_handle,
	output logic [15:0] host_count,
	output logic [15:0] local_count
);
	import bia_pkg::*;

	localparam int IDW         = $clog2(TOTAL_IDS);
	localparam int HOST_DEPTH  = HOST_IDS - 1;
	localparam int LOCAL_DEPTH = TOTAL_IDS - HOST_IDS;
	localparam int BAND_SIZE   = LOCAL_DEPTH / PEER_BANDS;
	localparam int HLW         = $clog2(HOST_DEPTH + 1);
	localparam int LLW         = $clog2(LOCAL_DEPTH + 1);

	fsm_state_t state_q, state_d;

	logic        clearing;
	logic        accept;
	logic        in_exec;

	logic [2:0]  op_s1;
	logic [15:0] id_s1;
	logic [15:0] hdl_s1;
	logic        popped_s1;

	logic [1:0]     active_band_q;
	logic [LLW-1:0] cap_q;

	stk_ctrl_t      host_ctrl, local_ctrl;
	logic [HLW-1:0] host_level;
	logic [LLW-1:0] local_level;
	logic [IDW-1:0] host_pop_id, local_pop_id;
	logic [LLW-1:0] band_level;
	logic [IDW-1:0] band_top;
	logic           band_load;

	map_ctrl_t      map_ctrl;
	logic [IDW-1:0] map_wr_addr;
	logic [15:0]    map_wr_data;
	logic [15:0]    map_rd_data;

	logic           bad_id;
	logic           is_host_id;
	logic [IDW-1:0] got_id;
	logic           push_req;
	logic [2:0]     status_d;
	logic [15:0]    rid_d;
	logic [15:0]    found_d;

	logic           done_q;
	logic [2:0]     status_q;
	logic [15:0]    rid_q;
	logic [15:0]    found_q;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: if (start && !clearing) state_d = FSM_EXEC;
			FSM_EXEC: state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		in_exec = 1'b0;
		unique case (state_q)
			FSM_IDLE: busy = clearing;
			FSM_EXEC: in_exec = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

	assign accept = start && !busy;

	// ---------------- accept stage ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= opcode;
			id_s1  <= element_id;
			hdl_s1 <= handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			popped_s1 <= 1'b0;
		end else if (accept) begin
			popped_s1 <= host_ctrl.pop || local_ctrl.pop;
		end
	end

	// ---------------- band register ----------------
	always_comb begin
		int base;
		int band_end;
		base     = HOST_IDS + int'(peer_band) * BAND_SIZE;
		band_end = (int'(peer_band) == PEER_BANDS - 1) ? TOTAL_IDS : base + BAND_SIZE;
		band_level = LLW'(band_end - base);
		band_top   = IDW'(band_end - 1);
		band_load  = peer_band_we && (peer_band != 2'd0)
			&& (int'(peer_band) < PEER_BANDS) && (peer_band != active_band_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_band_q <= 2'd0;
			cap_q         <= LLW'(BAND_SIZE);
		end else if (band_load) begin
			active_band_q <= peer_band;
			cap_q         <= band_level;
		end
	end

	// ---------------- execute stage ----------------
	assign bad_id     = (id_s1 == 16'd0) || ({1'b0, id_s1} >= 17'(TOTAL_IDS));
	assign is_host_id = ({1'b0, id_s1} < 17'(HOST_IDS));
	assign got_id     = (op_s1 == OP_ALLOC_HOST) ? host_pop_id : local_pop_id;

	always_comb begin
		status_d     = ST_OK;
		rid_d        = 16'd0;
		found_d      = 16'd0;
		map_ctrl     = '0;
		map_wr_addr  = id_s1[IDW-1:0];
		map_wr_data  = 16'd0;
		push_req     = 1'b0;
		unique case (op_s1)
			OP_ALLOC_HOST, OP_ALLOC_LOCAL: begin
				if (hdl_s1 == 16'd0) begin
					status_d = ST_NULL_HDL;
				end else if (!popped_s1) begin
					status_d = ST_EXHAUSTED;
				end else begin
					rid_d          = 16'(got_id);
					map_ctrl.wr_en = in_exec;
					map_wr_addr    = got_id;
					map_wr_data    = hdl_s1;
				end
			end
			OP_FREE: begin
				rid_d = id_s1;
				if (bad_id) begin
					status_d = ST_BAD_ID;
				end else if (map_rd_data == 16'd0) begin
					status_d = ST_EMPTY;
				end else begin
					map_ctrl.wr_en = in_exec;
					push_req       = in_exec;
				end
			end
			OP_REG_MIRROR: begin
				rid_d = id_s1;
				if (bad_id) begin
					status_d = ST_BAD_ID;
				end else if (hdl_s1 == 16'd0) begin
					status_d = ST_NULL_HDL;
				end else if (map_rd_data != 16'd0) begin
					status_d = ST_OCCUPIED;
				end else begin
					map_ctrl.wr_en = in_exec;
					map_wr_data    = hdl_s1;
				end
			end
			OP_UNREG: begin
				rid_d = id_s1;
				if (bad_id) begin
					status_d = ST_BAD_ID;
				end else if (map_rd_data == 16'd0) begin
					status_d = ST_EMPTY;
				end else begin
					map_ctrl.wr_en = in_exec;
				end
			end
			OP_LOOKUP: begin
				rid_d = id_s1;
				if (bad_id) begin
					status_d = ST_BAD_ID;
				end else begin
					found_d = map_rd_data;
					if (map_rd_data == 16'd0) begin
						status_d = ST_EMPTY;
					end
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		map_ctrl.rd_en = accept;
	end

	// pop at accept, push at execute
	always_comb begin
		host_ctrl       = '0;
		local_ctrl      = '0;
		host_ctrl.pop   = accept && (opcode == OP_ALLOC_HOST) && (handle != 16'd0)
			&& (host_level != '0);
		local_ctrl.pop  = accept && (opcode == OP_ALLOC_LOCAL) && (handle != 16'd0)
			&& (local_level != '0);
		host_ctrl.push  = push_req && is_host_id;
		local_ctrl.push = push_req && !is_host_id;
		local_ctrl.load = band_load;
	end

	bia_id_map #(
		.DEPTH (TOTAL_IDS),
		.DW    (16)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (map_ctrl),
		.rd_addr  (element_id[IDW-1:0]),
		.wr_addr  (map_wr_addr),
		.wr_data  (map_wr_data),
		.rd_data  (map_rd_data),
		.clearing (clearing)
	);

	bia_free_stack #(
		.DEPTH     (HOST_DEPTH),
		.IDW       (IDW),
		.RST_TOP   (HOST_IDS - 1),
		.RST_LEVEL (HOST_DEPTH)
	) u_host_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (host_ctrl),
		.load_level (HLW'(HOST_DEPTH)),
		.load_top   (IDW'(HOST_IDS - 1)),
		.push_id    (id_s1[IDW-1:0]),
		.level      (host_level),
		.pop_id     (host_pop_id)
	);

	bia_free_stack #(
		.DEPTH     (LOCAL_DEPTH),
		.IDW       (IDW),
		.RST_TOP   (HOST_IDS + BAND_SIZE - 1),
		.RST_LEVEL (BAND_SIZE)
	) u_local_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (local_ctrl),
		.load_level (band_level),
		.load_top   (band_top),
		.push_id    (id_s1[IDW-1:0]),
		.level      (local_level),
		.pop_id     (local_pop_id)
	);

	// ---------------- result registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_exec;
		end
	end

	always_ff @(posedge clk) begin
		if (in_exec) begin
			status_q <= status_d;
			rid_q    <= rid_d;
			found_q  <= found_d;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign result_id    = rid_q;
	assign found_handle = found_q;
	assign host_count   = 16'(HLW'(HOST_DEPTH) - host_level);
	assign local_count  = (local_level >= cap_q) ? 16'd0 : 16'(cap_q - local_level);

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == FSM_EXEC))
		else $error("result strobe without execute cycle");
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done_q)
		else $error("accepted item produced no result");
	a_busy_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> busy && state_q == FSM_IDLE)
		else $error("item accepted during map clearing");

endmodule
`default_nettype wire
